/* rtl/core/ccmb_pkg.sv */
// Package for the CIGAR coordinate map builder.
// Holds the operation, CIGAR code, status and register index constants and the state type.
// No dependencies.
package ccmb_pkg;

   localparam int unsigned OP_W      = 2;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned RUN_W     = 12;
   localparam int unsigned COL_W     = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [CODE_W-1:0] CODE_M  = 8'h4D;
   localparam logic [CODE_W-1:0] CODE_EQ = 8'h3D;
   localparam logic [CODE_W-1:0] CODE_X  = 8'h58;
   localparam logic [CODE_W-1:0] CODE_D  = 8'h44;
   localparam logic [CODE_W-1:0] CODE_N  = 8'h4E;
   localparam logic [CODE_W-1:0] CODE_H  = 8'h48;
   localparam logic [CODE_W-1:0] CODE_P  = 8'h50;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY_MODE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY_LENGTH = 4'd1;

   localparam logic [COL_W-1:0] FINAL_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH_FIRST,
      S_MATCH_STEP,
      S_LOOKUP,
      S_EMIT
   } state_type;

endpackage

/* rtl/core/cigar_coordinate_map_builder.sv */
// Top level of the CIGAR coordinate map builder: sequencer, slot map memory and result register.
// Depends on ccmb_pkg.
//
// One item at a time. Start, deletion, H/P, unsupported, unused-op, identity lookups and map
// lookups out of range go from S_IDLE straight to S_EMIT; a map lookup in range passes S_LOOKUP
// for the registered memory read; a match run passes S_MATCH_FIRST and then S_MATCH_STEP once
// per base, since the slot map has a single write port and each base writes one entry (a run
// cut short by overflow ends in the S_MATCH_STEP after the base that hits the limit). Every item
// waits in S_EMIT while the result register is held by rsp_stall. A new item is accepted while
// the previous result still waits on rsp_stall. The slot map holds MAX_SLOTS + 1 entries and is
// not cleared at reset: only entries written by start items and runs hold meaningful columns.
module cigar_coordinate_map_builder #(
   parameter int unsigned MAX_SLOTS = 4095
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ccmb_pkg::OP_W-1:0]          req_op,
   input  logic [ccmb_pkg::CODE_W-1:0]        req_run_code,
   input  logic [ccmb_pkg::RUN_W-1:0]         req_run_length,
   input  logic [ccmb_pkg::COL_W-1:0]         req_slot,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ccmb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ccmb_pkg::COL_W-1:0]         rsp_final_column,
   output logic [ccmb_pkg::RUN_W-1:0]         rsp_local_count,
   output logic [ccmb_pkg::COL_W-1:0]         rsp_final_count,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ccmb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ccmb_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int unsigned DEPTH = MAX_SLOTS + 1;
   localparam int unsigned LW    = $clog2(DEPTH);

   ccmb_pkg::state_type state_ff, state_in;

   logic                              identity_mode_ff;
   logic [ccmb_pkg::COL_W-1:0]        identity_length_ff;

   logic [LW-1:0]                     local_ff, local_in;
   logic [ccmb_pkg::COL_W-1:0]        final_ff, final_in;
   logic [ccmb_pkg::RUN_W-1:0]        remain_ff, remain_in;
   logic [ccmb_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [ccmb_pkg::COL_W-1:0]        column_ff, column_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ccmb_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [ccmb_pkg::COL_W-1:0]        rsp_column_ff;
   logic [ccmb_pkg::RUN_W-1:0]        rsp_local_ff;
   logic [ccmb_pkg::COL_W-1:0]        rsp_final_ff;

   logic [ccmb_pkg::COL_W-1:0]        map_mem [DEPTH];
   logic [ccmb_pkg::COL_W-1:0]        rd_data_ff;
   logic                              mem_we;
   logic [LW-1:0]                     mem_waddr;
   logic [ccmb_pkg::COL_W-1:0]        mem_wdata;
   logic [LW-1:0]                     mem_raddr;

   logic                              req_xfer;
   logic                              out_free;
   logic                              out_load;
   logic                              match_full;
   logic [LW-1:0]                     local_inc;
   logic [ccmb_pkg::COL_W:0]          del_sum;
   logic [ccmb_pkg::COL_W:0]          slot_ext;
   logic                              map_oor;

   assign req_stall = (state_ff != ccmb_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign match_full = (local_ff >= LW'(MAX_SLOTS)) || (final_ff == ccmb_pkg::FINAL_MAX);
   assign local_inc  = local_ff + 1'b1;
   assign del_sum    = {1'b0, final_ff} + (ccmb_pkg::COL_W + 1)'(req_run_length);
   assign slot_ext   = {1'b0, req_slot};
   assign map_oor    = (slot_ext > (ccmb_pkg::COL_W + 1)'(local_ff)) ||
                       (slot_ext > (ccmb_pkg::COL_W + 1)'(MAX_SLOTS));

   always_comb begin
      state_in  = state_ff;
      local_in  = local_ff;
      final_in  = final_ff;
      remain_in = remain_ff;
      status_in = status_ff;
      column_in = column_ff;
      mem_we    = 1'b0;
      mem_waddr = local_ff;
      mem_wdata = final_ff;
      mem_raddr = req_slot[LW-1:0];
      out_load  = 1'b0;

      unique case (state_ff)
         ccmb_pkg::S_IDLE: begin
            if (req_xfer) begin
               status_in = ccmb_pkg::ST_OK;
               column_in = '0;
               state_in  = ccmb_pkg::S_EMIT;
               unique case (req_op)
                  ccmb_pkg::OP_START: begin
                     local_in  = '0;
                     final_in  = '0;
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = '0;
                  end
                  ccmb_pkg::OP_RUN: begin
                     unique case (req_run_code)
                        ccmb_pkg::CODE_M, ccmb_pkg::CODE_EQ, ccmb_pkg::CODE_X: begin
                           remain_in = req_run_length;
                           state_in  = ccmb_pkg::S_MATCH_FIRST;
                        end
                        ccmb_pkg::CODE_D, ccmb_pkg::CODE_N: begin
                           mem_we = 1'b1;
                           if (del_sum > (ccmb_pkg::COL_W + 1)'(ccmb_pkg::FINAL_MAX)) begin
                              final_in  = ccmb_pkg::FINAL_MAX;
                              mem_wdata = ccmb_pkg::FINAL_MAX;
                              status_in = ccmb_pkg::ST_RANGE;
                           end else begin
                              final_in  = del_sum[ccmb_pkg::COL_W-1:0];
                              mem_wdata = del_sum[ccmb_pkg::COL_W-1:0];
                           end
                        end
                        ccmb_pkg::CODE_H, ccmb_pkg::CODE_P: begin
                           status_in = ccmb_pkg::ST_OK;
                        end
                        default: begin
                           status_in = ccmb_pkg::ST_UNSUPPORTED;
                        end
                     endcase
                  end
                  ccmb_pkg::OP_LOOKUP: begin
                     if (identity_mode_ff) begin
                        if (req_slot > identity_length_ff) begin
                           status_in = ccmb_pkg::ST_RANGE;
                        end else begin
                           column_in = req_slot;
                        end
                     end else if (map_oor) begin
                        status_in = ccmb_pkg::ST_RANGE;
                     end else begin
                        state_in = ccmb_pkg::S_LOOKUP;
                     end
                  end
                  default: begin
                     status_in = ccmb_pkg::ST_OK;
                  end
               endcase
            end
         end
         ccmb_pkg::S_MATCH_FIRST: begin
            if (remain_ff == '0) begin
               state_in = ccmb_pkg::S_EMIT;
            end else if (match_full) begin
               status_in = ccmb_pkg::ST_RANGE;
               state_in  = ccmb_pkg::S_EMIT;
            end else begin
               mem_we   = 1'b1;
               state_in = ccmb_pkg::S_MATCH_STEP;
            end
         end
         ccmb_pkg::S_MATCH_STEP: begin
            if (match_full) begin
               status_in = ccmb_pkg::ST_RANGE;
               state_in  = ccmb_pkg::S_EMIT;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = local_inc;
               mem_wdata = final_ff + 1'b1;
               local_in  = local_inc;
               final_in  = final_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
               if (remain_ff == ccmb_pkg::RUN_W'(1)) begin
                  state_in = ccmb_pkg::S_EMIT;
               end
            end
         end
         ccmb_pkg::S_LOOKUP: begin
            column_in = rd_data_ff;
            state_in  = ccmb_pkg::S_EMIT;
         end
         ccmb_pkg::S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ccmb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ccmb_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccmb_pkg::S_IDLE;
         local_ff     <= '0;
         final_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         local_ff     <= local_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         identity_mode_ff   <= 1'b1;
         identity_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == ccmb_pkg::CSR_IDENTITY_MODE) begin
            identity_mode_ff <= csr_data[0];
         end
         if (csr_index == ccmb_pkg::CSR_IDENTITY_LENGTH) begin
            identity_length_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      status_ff <= status_in;
      column_ff <= column_in;
      if (out_load) begin
         rsp_status_ff <= status_ff;
         rsp_column_ff <= column_ff;
         rsp_local_ff  <= ccmb_pkg::RUN_W'(local_ff);
         rsp_final_ff  <= final_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[mem_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_final_column = rsp_column_ff;
   assign rsp_local_count  = rsp_local_ff;
   assign rsp_final_count  = rsp_final_ff;

   a_local_bound: assert property (@(posedge clock) disable iff (reset)
      local_ff <= LW'(MAX_SLOTS))
      else $error("local position past table depth");

   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_waddr <= LW'(MAX_SLOTS))
      else $error("slot map write past table depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != ccmb_pkg::S_IDLE)
      else $error("transfer accepted without leaving idle");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("result load lost");

   a_lookup_from_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ccmb_pkg::S_LOOKUP |-> $past(state_ff) == ccmb_pkg::S_IDLE)
      else $error("lookup read without issue");

endmodule

/* tb/sv/cigar_coordinate_map_builder_tb.sv */
// Self-checking testbench for cigar_coordinate_map_builder: directed and random CIGAR run,
// start and lookup transfers with random idling, checked against an in-bench map predictor.
// Depends on ccmb_pkg and the cigar_coordinate_map_builder RTL.
`timescale 1ns / 1ps

module cigar_coordinate_map_builder_tb;

   localparam int unsigned SLOT_LIMIT   = 4095;
   localparam int unsigned CYCLE_LIMIT  = 2000000;
   localparam int unsigned PHASE_ITEMS  = 280;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [ccmb_pkg::STATUS_W-1:0] status;
      logic [ccmb_pkg::COL_W-1:0]    column;
      logic [ccmb_pkg::RUN_W-1:0]    local_count;
      logic [ccmb_pkg::COL_W-1:0]    final_count;
   } map_result_type;

   class coord_map_scoreboard_type;
      bit                          ident_mode;
      logic [ccmb_pkg::COL_W-1:0]  ident_len;
      int unsigned                 local_ctr;
      int unsigned                 final_ctr;
      logic [ccmb_pkg::COL_W-1:0]  column_map [0:SLOT_LIMIT];
      map_result_type              awaited_q [$];
      int unsigned                 mismatches;

      function new();
         ident_mode = 1'b1;
         ident_len  = '0;
         local_ctr  = 0;
         final_ctr  = 0;
         mismatches = 0;
      endfunction

      function void note_config(logic [ccmb_pkg::CSR_IDX_W-1:0] idx,
                                logic [ccmb_pkg::CSR_DAT_W-1:0] data);
         if (idx == ccmb_pkg::CSR_IDENTITY_MODE)
            ident_mode = data[0];
         else if (idx == ccmb_pkg::CSR_IDENTITY_LENGTH)
            ident_len = data;
      endfunction

      function void note_request(logic [ccmb_pkg::OP_W-1:0] op,
                                 logic [ccmb_pkg::CODE_W-1:0] code,
                                 logic [ccmb_pkg::RUN_W-1:0] len,
                                 logic [ccmb_pkg::COL_W-1:0] slot);
         map_result_type r;
         int unsigned    i;
         r.status = ccmb_pkg::ST_OK;
         r.column = '0;
         case (op)
            ccmb_pkg::OP_START: begin
               local_ctr     = 0;
               final_ctr     = 0;
               column_map[0] = '0;
            end
            ccmb_pkg::OP_RUN: begin
               case (code)
                  ccmb_pkg::CODE_M, ccmb_pkg::CODE_EQ, ccmb_pkg::CODE_X: begin
                     for (i = 0; i < len && r.status == ccmb_pkg::ST_OK; i++) begin
                        if (local_ctr >= SLOT_LIMIT ||
                            final_ctr >= 32'(ccmb_pkg::FINAL_MAX)) begin
                           r.status = ccmb_pkg::ST_RANGE;
                        end else begin
                           column_map[local_ctr] = final_ctr[ccmb_pkg::COL_W-1:0];
                           local_ctr++;
                           final_ctr++;
                           column_map[local_ctr] = final_ctr[ccmb_pkg::COL_W-1:0];
                        end
                     end
                  end
                  ccmb_pkg::CODE_D, ccmb_pkg::CODE_N: begin
                     if (final_ctr + 32'(len) > 32'(ccmb_pkg::FINAL_MAX)) begin
                        final_ctr = 32'(ccmb_pkg::FINAL_MAX);
                        r.status  = ccmb_pkg::ST_RANGE;
                     end else begin
                        final_ctr = final_ctr + 32'(len);
                     end
                     column_map[local_ctr] = final_ctr[ccmb_pkg::COL_W-1:0];
                  end
                  ccmb_pkg::CODE_H, ccmb_pkg::CODE_P: ;
                  default: r.status = ccmb_pkg::ST_UNSUPPORTED;
               endcase
            end
            ccmb_pkg::OP_LOOKUP: begin
               if (ident_mode) begin
                  if (slot > ident_len)
                     r.status = ccmb_pkg::ST_RANGE;
                  else
                     r.column = slot;
               end else begin
                  if (32'(slot) > local_ctr)
                     r.status = ccmb_pkg::ST_RANGE;
                  else
                     r.column = column_map[slot];
               end
            end
            default: ;
         endcase
         r.local_count = local_ctr[ccmb_pkg::RUN_W-1:0];
         r.final_count = final_ctr[ccmb_pkg::COL_W-1:0];
         awaited_q.insert(awaited_q.size(), r);
      endfunction

      function void check_result(map_result_type got);
         map_result_type want;
         if (awaited_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result transfer: status %0d column %0d local %0d final %0d",
                        got.status, got.column, got.local_count, got.final_count);
            return;
         end
         want = awaited_q.pop_front();
         if (got.status != want.status || got.column != want.column ||
             got.local_count != want.local_count || got.final_count != want.final_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result mismatch: expected status %0d column %0d local %0d final %0d, %s",
                        want.status, want.column, want.local_count, want.final_count,
                        $sformatf("got status %0d column %0d local %0d final %0d",
                                  got.status, got.column, got.local_count, got.final_count));
         end
      endfunction

      function int unsigned pending_count();
         return awaited_q.size();
      endfunction
   endclass

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_stall;
   logic [ccmb_pkg::OP_W-1:0]      req_op         = '0;
   logic [ccmb_pkg::CODE_W-1:0]    req_run_code   = '0;
   logic [ccmb_pkg::RUN_W-1:0]     req_run_length = '0;
   logic [ccmb_pkg::COL_W-1:0]     req_slot       = '0;
   logic                           rsp_valid;
   logic                           rsp_stall      = 1'b0;
   logic [ccmb_pkg::STATUS_W-1:0]  rsp_status;
   logic [ccmb_pkg::COL_W-1:0]     rsp_final_column;
   logic [ccmb_pkg::RUN_W-1:0]     rsp_local_count;
   logic [ccmb_pkg::COL_W-1:0]     rsp_final_count;
   logic                           csr_valid      = 1'b0;
   logic                           csr_ready;
   logic [ccmb_pkg::CSR_IDX_W-1:0] csr_index      = '0;
   logic [ccmb_pkg::CSR_DAT_W-1:0] csr_data       = '0;

   coord_map_scoreboard_type sb;
   int unsigned              send_idle_pct = 0;
   int unsigned              stall_pct     = 0;
   int unsigned              items_sent    = 0;
   int unsigned              cycles        = 0;

   cigar_coordinate_map_builder #(.MAX_SLOTS(SLOT_LIMIT)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_run_code     (req_run_code),
      .req_run_length   (req_run_length),
      .req_slot         (req_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_final_column (rsp_final_column),
      .rsp_local_count  (rsp_local_count),
      .rsp_final_count  (rsp_final_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[cigar_coordinate_map_builder] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_status, rsp_final_column, rsp_local_count, rsp_final_count});
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   task automatic send_item(input logic [ccmb_pkg::OP_W-1:0] op,
                            input logic [ccmb_pkg::CODE_W-1:0] code,
                            input logic [ccmb_pkg::RUN_W-1:0] len,
                            input logic [ccmb_pkg::COL_W-1:0] slot);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_run_code   <= code;
      req_run_length <= len;
      req_slot       <= slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, code, len, slot);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   task automatic write_config(input bit mode, input logic [ccmb_pkg::COL_W-1:0] len);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= ccmb_pkg::CSR_IDENTITY_MODE;
      csr_data  <= {{(ccmb_pkg::CSR_DAT_W-1){1'b0}}, mode};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(ccmb_pkg::CSR_IDENTITY_MODE, {{(ccmb_pkg::CSR_DAT_W-1){1'b0}}, mode});
      csr_index <= ccmb_pkg::CSR_IDENTITY_LENGTH;
      csr_data  <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(ccmb_pkg::CSR_IDENTITY_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   task automatic send_body_item();
      int unsigned                 sel;
      logic [ccmb_pkg::CODE_W-1:0] code;
      logic [ccmb_pkg::RUN_W-1:0]  len;
      logic [ccmb_pkg::COL_W-1:0]  slot;
      code = ccmb_pkg::CODE_W'($urandom);
      len  = ccmb_pkg::RUN_W'($urandom);
      slot = ccmb_pkg::COL_W'($urandom);
      sel  = $urandom_range(99);
      if (sel < 40) begin
         case ($urandom_range(2))
            0: code = ccmb_pkg::CODE_M;
            1: code = ccmb_pkg::CODE_EQ;
            default: code = ccmb_pkg::CODE_X;
         endcase
         len = ($urandom_range(49) == 0) ? ccmb_pkg::RUN_W'($urandom_range(1000, 4095)) :
                                           ccmb_pkg::RUN_W'($urandom_range(0, 12));
         send_item(ccmb_pkg::OP_RUN, code, len, slot);
      end else if (sel < 60) begin
         code = $urandom_range(1) ? ccmb_pkg::CODE_D : ccmb_pkg::CODE_N;
         len  = ($urandom_range(9) == 0) ? ccmb_pkg::RUN_W'($urandom_range(0, 4095)) :
                                           ccmb_pkg::RUN_W'($urandom_range(0, 20));
         send_item(ccmb_pkg::OP_RUN, code, len, slot);
      end else if (sel < 88) begin
         if (sb.ident_mode) begin
            case ($urandom_range(3))
               0, 1: slot = ccmb_pkg::COL_W'($urandom_range(0, sb.ident_len));
               2: slot = sb.ident_len + 1'b1;
               default: ;
            endcase
         end else begin
            case ($urandom_range(9))
               7, 8: slot = ccmb_pkg::COL_W'(sb.local_ctr + 1);
               9: ;
               default: slot = ccmb_pkg::COL_W'($urandom_range(0, sb.local_ctr));
            endcase
         end
         send_item(ccmb_pkg::OP_LOOKUP, code, len, slot);
      end else if (sel < 94) begin
         send_item(ccmb_pkg::OP_RUN, $urandom_range(1) ? ccmb_pkg::CODE_H : ccmb_pkg::CODE_P,
                   len, slot);
      end else begin
         send_item(ccmb_pkg::OP_RUN, code, len, slot);
      end
   endtask

   task automatic send_random_items(input int unsigned count);
      int unsigned target;
      int unsigned kind;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(49) == 0)
            wait_drained();
         kind = $urandom_range(99);
         if (kind < 10) begin
            send_item(ccmb_pkg::OP_W'($urandom), ccmb_pkg::CODE_W'($urandom),
                      ccmb_pkg::RUN_W'($urandom), ccmb_pkg::COL_W'($urandom));
         end else if (kind < 13) begin
            send_item(ccmb_pkg::OP_START, ccmb_pkg::CODE_W'($urandom),
                      ccmb_pkg::RUN_W'($urandom), ccmb_pkg::COL_W'($urandom));
            repeat ($urandom_range(15, 18))
               send_item(ccmb_pkg::OP_RUN,
                         $urandom_range(1) ? ccmb_pkg::CODE_D : ccmb_pkg::CODE_N,
                         ccmb_pkg::RUN_W'($urandom_range(3900, 4095)),
                         ccmb_pkg::COL_W'($urandom));
            repeat ($urandom_range(1, 4)) send_body_item();
         end else begin
            send_item(ccmb_pkg::OP_START, ccmb_pkg::CODE_W'($urandom),
                      ccmb_pkg::RUN_W'($urandom), ccmb_pkg::COL_W'($urandom));
            repeat ($urandom_range(2, 24)) send_body_item();
         end
      end
   endtask

   initial begin
      int unsigned phase;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_config(1'b0, 16'hFFFF);
            1: write_config(1'b1, 16'h0000);
            2: write_config(1'b1, 16'hFFFF);
            3: write_config(1'b0, ccmb_pkg::COL_W'($urandom));
            4: write_config(1'b1, ccmb_pkg::COL_W'($urandom));
            default: write_config(1'b1, ccmb_pkg::COL_W'($urandom_range(0, 4095)));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         if (phase == 0) begin
            send_item(ccmb_pkg::OP_START,  8'h00,            12'd0,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_M,  12'd5,   16'hFFFF);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_EQ, 12'd0,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_X,  12'd3,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_D,  12'd0,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_N,  12'd7,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_H,  12'hFFF, 16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_P,  12'd1,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    8'h49,            12'd2,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    8'hFF,            12'hFFF, 16'd0);
            send_item(ccmb_pkg::OP_RUN,    8'h00,            12'd1,   16'd0);
            send_item(2'd3,                8'hFF,            12'hFFF, 16'hFFFF);
            send_item(ccmb_pkg::OP_LOOKUP, 8'h00,            12'd0,   16'd0);
            send_item(ccmb_pkg::OP_LOOKUP, 8'h00,            12'd0,   16'd4);
            send_item(ccmb_pkg::OP_LOOKUP, 8'h00,            12'd0,   16'd8);
            send_item(ccmb_pkg::OP_LOOKUP, 8'h00,            12'd0,   16'd9);
            send_item(ccmb_pkg::OP_LOOKUP, 8'hFF,            12'hFFF, 16'hFFFF);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_M,  12'hFFF, 16'd0);
            send_item(ccmb_pkg::OP_LOOKUP, 8'h00,            12'd0,   16'd4095);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_D,  12'hFFF, 16'd0);
            send_item(ccmb_pkg::OP_START,  8'h00,            12'd0,   16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_M,  12'hFFF, 16'd0);
            send_item(ccmb_pkg::OP_RUN,    ccmb_pkg::CODE_X,  12'd1,   16'd0);
            send_item(ccmb_pkg::OP_START,  8'h00,            12'd0,   16'd0);
         end
         send_random_items(PHASE_ITEMS);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("[cigar_coordinate_map_builder] OK");
      else
         $display("[cigar_coordinate_map_builder] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ccmb_pkg.sv
rtl/core/cigar_coordinate_map_builder.sv
tb/sv/cigar_coordinate_map_builder_tb.sv
